### hdl/twis_pkg.sv
// Shared types, codes and defaults for the letter trie insert and search block.
package twis_pkg;

	localparam int NODE_COUNT_DEF    = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;

	localparam int OPCODE_W = 2;
	localparam int LETTER_W = 5;

	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_PREFIX = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [LETTER_W-1:0] letter;
		logic                last_letter;
		logic                empty_word;
	} twis_in_t;

	typedef struct packed {
		logic answer;
		logic pool_full;
	} twis_out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} twis_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic walk;
		logic fin_read;
		logic finish;
	} twis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic item_last;
	} twis_stat_t;

endpackage

### hdl/twis_ctrl.sv
// Controller state machine sequencing the clearing pass, letter walk and word finish.
module twis_ctrl import twis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       empty_word,
	input  twis_stat_t stat,
	output twis_cmd_t  cmd,
	output logic       busy
);

	twis_state_t state_q;
	twis_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_next = empty_word ? ST_FINISH : ST_WALK;
				end
			end
			ST_WALK: begin
				state_next = stat.item_last ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_WALK: begin
				cmd.walk     = 1'b1;
				cmd.fin_read = stat.item_last;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/twis_datapath.sv
// Datapath: node row memory, walk registers, node allocation and result register.
module twis_datapath import twis_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  twis_cmd_t  cmd,
	input  twis_in_t   item,
	output twis_stat_t stat,
	output twis_out_t  result,
	output logic       done
);

	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	// Each row holds one child pointer per letter with the end mark on top.
	localparam int RW = ALPHABET_SIZE * NW + 1;

	logic [RW-1:0] node_mem_q [NODE_COUNT];
	logic [RW-1:0] row_q;

	twis_in_t      item_q;
	logic [NW-1:0] cur_q;
	logic [NW:0]   next_free_q;
	logic          missed_q;
	logic          dropped_q;
	logic [NW-1:0] clr_addr_q;
	twis_out_t     result_q;
	logic          done_q;

	logic [NW-1:0] child;
	logic [RW-1:0] new_row;
	logic          letter_ok;
	logic          go;
	logic          can_alloc;
	logic          alloc;
	logic [NW-1:0] walk_cur;
	logic          mark_end;

	logic          rd_en;
	logic [NW-1:0] rd_addr;
	logic          wr_en;
	logic [NW-1:0] wr_addr;
	logic [RW-1:0] wr_data;

	// Child lookup and the row with the allocated child filled in.
	always_comb begin
		child   = '0;
		new_row = row_q;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			if (32'(item_q.letter) == i) begin
				child                 = row_q[i*NW +: NW];
				new_row[i*NW +: NW]   = next_free_q[NW-1:0];
			end
		end
	end

	assign letter_ok = 32'(item_q.letter) < ALPHABET_SIZE;
	assign go        = !missed_q && !dropped_q && letter_ok;
	assign can_alloc = next_free_q < (NW+1)'(NODE_COUNT);
	assign alloc     = go && (child == '0) && (item_q.opcode == OP_INSERT) && can_alloc;

	always_comb begin
		walk_cur = cur_q;
		if (go) begin
			if (child != '0) begin
				walk_cur = child;
			end else if (alloc) begin
				walk_cur = next_free_q[NW-1:0];
			end
		end
	end

	assign mark_end = cmd.finish && (item_q.opcode == OP_INSERT) && !dropped_q && !missed_q;

	// Memory port selection.
	always_comb begin
		rd_en   = cmd.accept || cmd.fin_read;
		rd_addr = walk_cur;
		if (cmd.accept) begin
			rd_addr = item.empty_word ? '0 : cur_q;
		end
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = new_row;
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.walk && alloc) begin
			wr_en   = 1'b1;
		end else if (mark_end) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, row_q[RW-2:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_q <= node_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.answer    <= 1'b0;
			result_q.pool_full <= 1'b0;
			if (item_q.opcode == OP_INSERT) begin
				if (dropped_q) begin
					result_q.pool_full <= 1'b1;
				end else if (!missed_q) begin
					result_q.answer <= 1'b1;
				end
			end else if (!missed_q && !dropped_q) begin
				result_q.answer <= (item_q.opcode == OP_SEARCH) ? row_q[RW-1] : 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			next_free_q <= (NW+1)'(1);
			missed_q    <= 1'b0;
			dropped_q   <= 1'b0;
			clr_addr_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + NW'(1);
			end
			if (cmd.accept && item.empty_word) begin
				// An empty word abandons any word in progress.
				cur_q     <= '0;
				missed_q  <= 1'b0;
				dropped_q <= 1'b0;
			end else if (cmd.walk) begin
				cur_q <= walk_cur;
				if (alloc) begin
					next_free_q <= next_free_q + (NW+1)'(1);
				end
				if (go && (child == '0) && !alloc) begin
					if (item_q.opcode == OP_INSERT) begin
						dropped_q <= 1'b1;
					end else begin
						missed_q <= 1'b1;
					end
				end
			end else if (cmd.finish) begin
				cur_q     <= '0;
				missed_q  <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

	assign stat.clear_last = (clr_addr_q == NW'(NODE_COUNT - 1));
	assign stat.item_last  = item_q.last_letter;
	assign result          = result_q;
	assign done            = done_q;

endmodule

### hdl/trie_word_insert_search_top.sv
// Top level of the letter trie insert and search block.
//
// Words arrive one letter per item; an item is taken when start is high and busy is low.
// A letter passes through the idle and walk states and a final letter then through finish;
// an empty word goes through idle and finish. Every letter needs one registered read of its
// node's row from the node memory before the child pointer is known, and the final letter
// needs a second read of the node it lands on to test or set the end mark. The result of a
// word appears on result with done high for a single cycle, in the cycle after the finish
// state; it cannot be held off, so the receiver must take it then. After reset the block
// clears all NODE_COUNT rows of the node memory one row per cycle and stays busy meanwhile.
module trie_word_insert_search_top import twis_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  twis_in_t  item,
	output logic      done,
	output twis_out_t result
);

	twis_cmd_t  cmd;
	twis_stat_t stat;

	twis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.empty_word (item.empty_word),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	twis_datapath #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule

### tb/trie_answer_checker.sv
`timescale 1ns / 1ps
// Checker for the letter trie: tracks the trie from accepted items and compares each answer.
module trie_answer_checker import twis_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  twis_in_t  item,
	input  logic      done,
	input  twis_out_t result,
	output int        fail_count,
	output int        words_pending,
	output logic      pool_used_up
);

	int        child_of [NODE_COUNT*ALPHABET_SIZE];
	bit        end_mark [NODE_COUNT];
	int        free_node;
	int        cur_node;
	bit        missed;
	bit        dropped;
	twis_out_t expected_answers [$];
	twis_out_t oldest;
	int        mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Ends the word in progress: queues its answer and returns the walk to the root.
	task automatic close_word(input logic [OPCODE_W-1:0] op);
		twis_out_t res;
		res = '0;
		if (op == OP_INSERT) begin
			if (dropped)
				res.pool_full = 1'b1;
			else if (!missed) begin
				end_mark[cur_node] = 1'b1;
				res.answer = 1'b1;
			end
		end else if (!missed && !dropped) begin
			// Anything that is neither insert nor search behaves as a prefix test.
			res.answer = (op == OP_SEARCH) ? end_mark[cur_node] : 1'b1;
		end
		expected_answers.push_back(res);
		cur_node = 0;
		missed = 1'b0;
		dropped = 1'b0;
	endtask

	task automatic trie_walk(input twis_in_t it);
		int slot;
		if (it.empty_word) begin
			cur_node = 0;
			missed = 1'b0;
			dropped = 1'b0;
			close_word(it.opcode);
		end else begin
			if (!missed && !dropped && it.letter < ALPHABET_SIZE) begin
				slot = cur_node * ALPHABET_SIZE + it.letter;
				if (child_of[slot] != 0)
					cur_node = child_of[slot];
				else if (it.opcode == OP_INSERT) begin
					if (free_node < NODE_COUNT) begin
						child_of[slot] = free_node;
						cur_node = free_node;
						free_node++;
					end else
						dropped = 1'b1;
				end else
					missed = 1'b1;
			end
			if (it.last_letter)
				close_word(it.opcode);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT*ALPHABET_SIZE; i++)
				child_of[i] = 0;
			for (int i = 0; i < NODE_COUNT; i++)
				end_mark[i] = 1'b0;
			free_node = 1;
			cur_node = 0;
			missed = 1'b0;
			dropped = 1'b0;
			expected_answers.delete();
			words_pending <= 0;
			pool_used_up <= 1'b0;
		end else begin
			if (start && !busy)
				trie_walk(item);
			if (done) begin
				if (expected_answers.size() == 0)
					report_mismatch($sformatf("answer %0b pool_full %0b with no word pending",
						result.answer, result.pool_full));
				else begin
					oldest = expected_answers.pop_front();
					if (result.answer !== oldest.answer)
						report_mismatch($sformatf("answer %0b, expected %0b",
							result.answer, oldest.answer));
					if (result.pool_full !== oldest.pool_full)
						report_mismatch($sformatf("pool_full %0b, expected %0b",
							result.pool_full, oldest.pool_full));
				end
			end
			words_pending <= expected_answers.size();
			pool_used_up <= (free_node >= NODE_COUNT);
		end
	end

endmodule

### tb/tb_trie_word_insert_search_top.sv
`timescale 1ns / 1ps
// Testbench top for the letter trie: clock, reset, word stimulus and the final verdict.
module tb_trie_word_insert_search_top import twis_pkg::*;;

	localparam int NODES   = NODE_COUNT_DEF;
	localparam int LETTERS = ALPHABET_SIZE_DEF;
	localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
	localparam byte LETTER_A = 8'h61;
	localparam int BANK_SIZE = 128;
	localparam int WORD_MAX  = 16;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	twis_in_t  item;
	logic      done;
	twis_out_t result;
	int        fail_count;
	int        words_pending;
	logic      pool_used_up;

	bit         steady;
	int         items_sent;
	logic [4:0] bank_letters [BANK_SIZE][WORD_MAX];
	int         bank_len [BANK_SIZE];
	int         bank_n;

	trie_word_insert_search_top #(
		.NODE_COUNT    (NODES),
		.ALPHABET_SIZE (LETTERS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	trie_answer_checker #(
		.NODE_COUNT    (NODES),
		.ALPHABET_SIZE (LETTERS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.done          (done),
		.result        (result),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.pool_used_up  (pool_used_up)
	);

	always #1 clk = ~clk;

	// Mostly back to back or short gaps, now and then a long one.
	task automatic send_item(input twis_in_t it);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_empty(input logic [OPCODE_W-1:0] op);
		twis_in_t it;
		it.opcode = op;
		it.letter = LETTER_W'($urandom_range(0, 31));
		it.last_letter = 1'($urandom_range(0, 1));
		it.empty_word = 1'b1;
		send_item(it);
	endtask

	task automatic send_letters(input logic [OPCODE_W-1:0] op, input string s);
		twis_in_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.opcode = op;
			it.letter = LETTER_W'(s[i] - LETTER_A);
			it.last_letter = (i == s.len() - 1);
			it.empty_word = 1'b0;
			send_item(it);
		end
	endtask

	task automatic send_raw(input logic [OPCODE_W-1:0] op, input logic [4:0] letter,
		input logic last);
		twis_in_t it;
		it.opcode = op;
		it.letter = letter;
		it.last_letter = last;
		it.empty_word = 1'b0;
		send_item(it);
	endtask

	// One word with random content; in fill mode a long insert that uses up fresh nodes.
	task automatic random_word(input bit fill);
		logic [OPCODE_W-1:0] op;
		logic [4:0]          w [WORD_MAX];
		twis_in_t            it;
		int                  len;
		int                  r;
		int                  k;
		steady = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 99);
		if (fill || r < 40)
			op = OP_INSERT;
		else if (r < 70)
			op = OP_SEARCH;
		else if (r < 95)
			op = OP_PREFIX;
		else
			op = OP_RESERVED;
		if (!fill && $urandom_range(0, 24) == 0) begin
			send_empty(op);
			return;
		end
		if (!fill && bank_n > 0 && $urandom_range(0, 1) == 1) begin
			k = $urandom_range(0, bank_n - 1);
			len = bank_len[k];
			for (int i = 0; i < len; i++)
				w[i] = bank_letters[k][i];
			// Cut a known word short or run one letter past it to reach prefixes and near misses.
			r = $urandom_range(0, 3);
			if (r == 0)
				len = $urandom_range(1, len);
			else if (r == 1 && len < WORD_MAX) begin
				w[len] = 5'($urandom_range(0, LETTERS - 1));
				len++;
			end
		end else begin
			len = fill ? $urandom_range(10, WORD_MAX) : $urandom_range(1, 6);
			r = $urandom_range(0, 1);
			for (int i = 0; i < len; i++)
				w[i] = r ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, LETTERS - 1));
		end
		for (int i = 0; i < len; i++) begin
			it.opcode = op;
			it.letter = w[i];
			it.last_letter = (i == len - 1);
			it.empty_word = 1'b0;
			if (!fill) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					// Abandon the word with an empty one.
					send_empty(OPCODE_W'($urandom_range(0, 3)));
					return;
				end else if (r < 7)
					it.letter = LETTER_W'($urandom_range(LETTERS, 31));
				else if (r < 10 && i < len - 1)
					it.opcode = OPCODE_W'($urandom_range(0, 3));
			end
			send_item(it);
		end
		if (op == OP_INSERT) begin
			if (bank_n < BANK_SIZE) begin
				k = bank_n;
				bank_n++;
			end else
				k = $urandom_range(0, BANK_SIZE - 1);
			bank_len[k] = len;
			for (int i = 0; i < len; i++)
				bank_letters[k][i] = w[i];
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		steady = 1'b0;
		items_sent = 0;
		bank_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words on an empty trie.
		send_empty(OP_SEARCH);
		send_empty(OP_PREFIX);
		send_letters(OP_SEARCH, "a");
		send_letters(OP_INSERT, "a");
		send_letters(OP_INSERT, "zz");
		send_letters(OP_SEARCH, "z");
		send_letters(OP_PREFIX, "z");
		send_letters(OP_SEARCH, "zz");
		send_letters(OP_RESERVED, "zz");
		// A letter past the alphabet leaves the walk where it is.
		send_raw(OP_INSERT, 5'd0, 1'b0);
		send_raw(OP_INSERT, 5'd31, 1'b0);
		send_raw(OP_INSERT, 5'd1, 1'b1);
		send_letters(OP_SEARCH, "ab");
		send_raw(OP_SEARCH, 5'd30, 1'b1);
		send_empty(OP_INSERT);
		send_empty(OP_SEARCH);
		// An empty word part way through a word drops what came before.
		send_raw(OP_INSERT, 5'd16, 1'b0);
		send_empty(OP_SEARCH);
		send_letters(OP_SEARCH, "q");
		// An insert that ends after a missed search letter completes nothing.
		send_raw(OP_SEARCH, 5'd23, 1'b0);
		send_raw(OP_INSERT, 5'd24, 1'b1);
		send_letters(OP_PREFIX, "y");
		// The opcode on the final item decides the kind of answer.
		send_raw(OP_INSERT, 5'd12, 1'b0);
		send_raw(OP_SEARCH, 5'd13, 1'b1);

		while (items_sent < 200)
			random_word(1'b0);
		// Long inserts until the node pool is used up, then a few more that must be dropped.
		for (int n = 0; n < 150 && !pool_used_up; n++)
			random_word(1'b1);
		repeat (5) random_word(1'b1);
		while (items_sent < 1600)
			random_word(1'b0);

		start <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("tb_trie_word_insert_search_top: clean");
		else
			$display("tb_trie_word_insert_search_top: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_trie_word_insert_search_top: errors");
		$finish;
	end

endmodule
